// File: rtl/xmltok_pkg.sv
// Shared types, character constants and character class functions for the
// markup tokenizer. Depends on nothing; every other file imports it.
package xmltok_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int RES_DEPTH       = 4;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [3:0] {
    K_BYTE   = 4'd0,
    K_TAG    = 4'd1,
    K_ATTR   = 4'd2,
    K_ASSIGN = 4'd3,
    K_VALUE  = 4'd4,
    K_TEXT   = 4'd5,
    K_CLOSE  = 4'd6,
    K_EMPTY  = 4'd7,
    K_ENDTAG = 4'd8,
    K_END    = 4'd9,
    K_ERROR  = 4'd10
  } kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } char_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_out;
    logic [15:0] token_length;
    logic        last;
  } tok_t;

  // Results of one request handed from the scanner to the result queue.
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       r0;
    tok_t       r1;
  } push_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

endpackage

// File: rtl/xmltok_core.sv
// Input register and scan mode machine of the markup tokenizer: forms up to
// two results per request. Depends on xmltok_pkg.
module xmltok_core import xmltok_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  char_valid,
  output logic  char_stall,
  input  char_t char_data,
  input  logic  room,
  output push_t push
);

  typedef enum logic [3:0] {
    M_CONTENT = 4'd0,
    M_TEXT    = 4'd1,
    M_LT      = 4'd2,
    M_ENDNAME = 4'd3,
    M_TAGNAME = 4'd4,
    M_INTAG   = 4'd5,
    M_ATTR    = 4'd6,
    M_VALUE   = 4'd7,
    M_SLASH   = 4'd8,
    M_DONE    = 4'd9,
    M_ERROR   = 4'd10
  } mode_t;

  mode_t                  mode, mode_next;
  logic                   qd, qd_next;
  logic [LENGTH_BITS-1:0] len, len_next, len_inc;
  logic [LENGTH_BITS+15:0] len_ext;
  char_t                  in_q;
  logic                   in_q_valid;
  logic                   fire, accept;
  logic [7:0]             c;
  logic                   eot;

  logic  it_emit, it_start, it_quote;
  tok_t  it_rec;
  mode_t it_mode;
  tok_t  byte_rec, fin_rec, end_rec, err_rec;
  push_t res;

  assign char_stall = in_q_valid && !room;
  assign accept     = char_valid && !char_stall;
  assign fire       = in_q_valid && room;
  assign c          = in_q.ch;
  assign eot        = in_q.end_of_text || (in_q.ch == CH_NUL);

  assign len_inc = (len != {LENGTH_BITS{1'b1}}) ? len + 1'b1 : len;
  assign len_ext = {16'd0, len};

  always_comb begin
    byte_rec = '{kind: K_BYTE, byte_out: c, token_length: 16'd0, last: 1'b0};
    fin_rec  = '{kind: K_TEXT, byte_out: 8'd0, token_length: len_ext[15:0], last: 1'b0};
    end_rec  = '{kind: K_END, byte_out: 8'd0, token_length: 16'd0, last: 1'b0};
    err_rec  = '{kind: K_ERROR, byte_out: 8'd0, token_length: 16'd0, last: 1'b0};
  end

  // Reading of one byte between tokens inside a tag.
  always_comb begin
    it_emit  = 1'b1;
    it_start = 1'b0;
    it_quote = 1'b0;
    it_rec   = err_rec;
    it_mode  = M_INTAG;
    if (eot) begin
      it_rec  = end_rec;
      it_mode = M_DONE;
    end else if (is_space(c)) begin
      it_emit = 1'b0;
    end else if (is_alpha(c)) begin
      it_rec   = byte_rec;
      it_start = 1'b1;
      it_mode  = M_ATTR;
    end else if (c == CH_EQ) begin
      it_rec      = err_rec;
      it_rec.kind = K_ASSIGN;
    end else if (c == CH_DQUOT || c == CH_SQUOT) begin
      it_emit  = 1'b0;
      it_quote = 1'b1;
      it_mode  = M_VALUE;
    end else if (c == CH_SLASH) begin
      it_emit = 1'b0;
      it_mode = M_SLASH;
    end else if (c == CH_GT) begin
      it_rec      = err_rec;
      it_rec.kind = K_CLOSE;
      it_mode     = M_CONTENT;
    end else begin
      it_mode = M_ERROR;
    end
  end

  always_comb begin
    res       = '{cnt: 2'd0, r0: end_rec, r1: end_rec};
    mode_next = mode;
    len_next  = len;
    qd_next   = qd;
    unique case (mode)
      M_CONTENT: begin
        if (eot) begin
          res.cnt = 2'd1; res.r0 = end_rec; mode_next = M_DONE;
        end else if (is_space(c)) begin
          res.cnt = 2'd0;
        end else if (c == CH_LT) begin
          mode_next = M_LT;
        end else if (c == CH_GT) begin
          res.cnt = 2'd1; res.r0 = err_rec; mode_next = M_ERROR;
        end else begin
          res.cnt = 2'd1; res.r0 = byte_rec;
          len_next = LENGTH_BITS'(1); mode_next = M_TEXT;
        end
      end
      M_TEXT: begin
        if (eot || c == CH_LT || c == CH_GT) begin
          res.r0 = fin_rec;
          len_next = '0;
          if (eot) begin
            res.cnt = 2'd2; res.r1 = end_rec; mode_next = M_DONE;
          end else if (c == CH_LT) begin
            res.cnt = 2'd1; mode_next = M_LT;
          end else begin
            res.cnt = 2'd2; res.r1 = err_rec; mode_next = M_ERROR;
          end
        end else begin
          res.cnt = 2'd1; res.r0 = byte_rec; len_next = len_inc;
        end
      end
      M_LT: begin
        if (eot) begin
          res.cnt = 2'd1; res.r0 = end_rec; mode_next = M_DONE;
        end else if (c == CH_SLASH) begin
          len_next = '0; mode_next = M_ENDNAME;
        end else if (is_alpha(c)) begin
          res.cnt = 2'd1; res.r0 = byte_rec;
          len_next = LENGTH_BITS'(1); mode_next = M_TAGNAME;
        end else begin
          res.cnt = 2'd1; res.r0 = err_rec; mode_next = M_ERROR;
        end
      end
      M_ENDNAME: begin
        if (eot) begin
          res.cnt = 2'd1; res.r0 = end_rec; mode_next = M_DONE;
        end else if (is_alnum(c)) begin
          res.cnt = 2'd1; res.r0 = byte_rec; len_next = len_inc;
        end else if (c == CH_GT) begin
          res.cnt = 2'd1; res.r0 = fin_rec; res.r0.kind = K_ENDTAG;
          len_next = '0; mode_next = M_CONTENT;
        end else begin
          res.cnt = 2'd1; res.r0 = err_rec; mode_next = M_ERROR;
        end
      end
      M_TAGNAME, M_ATTR: begin
        if (!eot && is_alnum(c)) begin
          res.cnt = 2'd1; res.r0 = byte_rec; len_next = len_inc;
        end else begin
          // The terminating byte is read again as the start of the next token.
          res.r0      = fin_rec;
          res.r0.kind = (mode == M_TAGNAME) ? K_TAG : K_ATTR;
          res.r1      = it_rec;
          res.cnt     = it_emit ? 2'd2 : 2'd1;
          mode_next   = it_mode;
          len_next    = it_start ? LENGTH_BITS'(1) : '0;
          if (it_quote) qd_next = (c == CH_DQUOT);
        end
      end
      M_INTAG: begin
        res.r0    = it_rec;
        res.cnt   = it_emit ? 2'd1 : 2'd0;
        mode_next = it_mode;
        if (it_start) len_next = LENGTH_BITS'(1);
        else if (it_quote) len_next = '0;
        if (it_quote) qd_next = (c == CH_DQUOT);
      end
      M_VALUE: begin
        if (eot) begin
          res.cnt = 2'd1; res.r0 = end_rec; mode_next = M_DONE;
        end else if (c == (qd ? CH_DQUOT : CH_SQUOT)) begin
          res.cnt = 2'd1; res.r0 = fin_rec; res.r0.kind = K_VALUE;
          len_next = '0; mode_next = M_INTAG;
        end else begin
          res.cnt = 2'd1; res.r0 = byte_rec; len_next = len_inc;
        end
      end
      M_SLASH: begin
        if (eot) begin
          res.cnt = 2'd1; res.r0 = end_rec; mode_next = M_DONE;
        end else if (c == CH_GT) begin
          res.cnt = 2'd1; res.r0 = err_rec; res.r0.kind = K_EMPTY;
          mode_next = M_CONTENT;
        end else begin
          res.cnt = 2'd1; res.r0 = err_rec; mode_next = M_ERROR;
        end
      end
      M_DONE: begin
        res.cnt = 2'd1; res.r0 = end_rec;
      end
      default: begin
        res.cnt = 2'd1; res.r0 = err_rec; mode_next = M_ERROR;
      end
    endcase
    res.r0.last = (res.cnt == 2'd1);
    res.r1.last = 1'b1;
    push        = res;
    if (!fire) push.cnt = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_CONTENT;
      qd         <= 1'b0;
      len        <= '0;
      in_q_valid <= 1'b0;
    end else begin
      if (fire) begin
        mode <= mode_next;
        qd   <= qd_next;
        len  <= len_next;
      end
      if (accept) in_q_valid <= 1'b1;
      else if (fire) in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_q <= char_data;
  end

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    mode == M_DONE |=> mode == M_DONE)
    else $error("end state left before reset");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    mode == M_ERROR |=> mode == M_ERROR)
    else $error("error state left before reset");

  a_done_one_end: assert property (@(posedge clk) disable iff (rst)
    (fire && mode == M_DONE) |-> (push.cnt == 2'd1 && push.r0.kind == K_END))
    else $error("end state must repeat a single end result");

  a_len_zero_intag: assert property (@(posedge clk) disable iff (rst)
    mode == M_INTAG |-> len == '0)
    else $error("length count not cleared between tag tokens");

endmodule

// File: rtl/xmltok_rfifo.sv
// Result queue of the markup tokenizer: takes up to two results a cycle and
// delivers one a cycle while tok_stall is low. Depends on xmltok_pkg.
module xmltok_rfifo import xmltok_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  tok_valid,
  input  logic  tok_stall,
  output tok_t  tok_data
);

  localparam int PW = $clog2(RES_DEPTH);
  localparam int CW = $clog2(RES_DEPTH + 1);

  tok_t           mem [RES_DEPTH];
  logic [PW-1:0]  wptr, rptr;
  logic [CW-1:0]  count, count_next;
  logic           pop;

  assign room      = count <= CW'(RES_DEPTH - 2);
  assign tok_valid = count != '0;
  assign tok_data  = mem[rptr];
  assign pop       = tok_valid && !tok_stall;

  assign count_next = count + CW'(push.cnt) - CW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PW'(push.cnt);
      if (pop) rptr <= rptr + 1'b1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wptr] <= push.r0;
    if (push.cnt == 2'd2) mem[wptr + 1'b1] <= push.r1;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.cnt != 2'd0 |-> room)
    else $error("results pushed without room");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) + CW'($past(push.cnt)) - CW'($past(pop)))
    else $error("queue count out of step with pushes and pops");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(RES_DEPTH))
    else $error("queue count beyond depth");

endmodule

// File: rtl/xml_markup_tokenizer_unit.sv
// Streaming tokenizer for simplified XML markup: one character in per
// request, token text bytes and completed tokens out, up to two results per
// character. Every character is scanned from its input register, so a new
// character is taken each cycle while the four-entry result queue has room
// for two more results; the output side drains one result per cycle while
// tok_stall is low, which sets the sustained rate at one character per cycle
// when each causes at most one result. End and error repeat until reset.
// Depends on xmltok_pkg, xmltok_core and xmltok_rfifo.
module xml_markup_tokenizer_unit import xmltok_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  char_valid,
  output logic  char_stall,
  input  char_t char_data,
  output logic  tok_valid,
  input  logic  tok_stall,
  output tok_t  tok_data
);

  push_t push;
  logic  room;

  xmltok_core #(.LENGTH_BITS(LENGTH_BITS)) u_core (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data),
    .room       (room),
    .push       (push)
  );

  xmltok_rfifo u_rfifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_data  (tok_data)
  );

endmodule
